// ===== design/gha_pkg.sv =====
`default_nettype none
// ============================================================================
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ============================================================================
package gha_pkg;

    localparam int ID_W            = 10;
    localparam int GEN_W           = 32;
    localparam int OP_W            = 3;
    localparam int MAX_HANDLES_DEF = 1024;
    localparam int GEN_BITS_DEF    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_CREATE_AT = 3'd1,
        OP_DESTROY   = 3'd2,
        OP_CHECK     = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  handle_id;
        logic [GEN_W-1:0] handle_gen;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]  out_id;
        logic [GEN_W-1:0] out_gen;
        logic             ok;
    } t_rsp;

    // state updates decided by the execute stage
    typedef struct packed {
        logic push;      // destroyed id goes onto the free stack
        logic pop;       // create took the free stack top
        logic row_we;    // write live bit and generation of row_addr
        logic row_live;
        logic clear;     // clear all: reset counters, start table sweep
    } t_upd;

endpackage : gha_pkg
`default_nettype wire

// ===== design/gha_ram.sv =====
`default_nettype none
// ============================================================================
// gha_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : gha_ram
`default_nettype wire

// ===== design/gha_exec.sv =====
`default_nettype none
// ============================================================================
// gha_exec
// Execute stage: decides result and state updates for one operation.
// ============================================================================
module gha_exec
    import gha_pkg::*;
#(
    parameter int MAX_HANDLES = MAX_HANDLES_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
) (
    input  wire logic                               i_valid,
    input  wire t_req                               i_req,
    input  wire logic                               i_row_live,
    input  wire logic [GEN_BITS-1:0]                i_row_gen,
    input  wire logic [$clog2(MAX_HANDLES)-1:0]     i_top_id,
    input  wire logic [$clog2(MAX_HANDLES+1)-1:0]   i_count,
    input  wire logic [$clog2(MAX_HANDLES+1)-1:0]   i_next_id,
    output t_upd                                    o_upd,
    output logic      [$clog2(MAX_HANDLES)-1:0]     o_row_addr,
    output logic      [GEN_BITS-1:0]                o_row_gen,
    output logic      [$clog2(MAX_HANDLES+1)-1:0]   o_next_id,
    output t_rsp                                    o_rsp
);

    localparam int AW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(MAX_HANDLES + 1);

    logic [AW+ID_W-1:0] id_ext;
    logic [AW-1:0]      id_addr;
    logic [AW+ID_W-1:0] nid_ext;
    logic [AW-1:0]      nid;
    logic               in_range;
    logic               gen_match;
    logic [CW-1:0]      id_p1;
    logic [GEN_BITS-1:0] gen_masked;

    always_comb begin
        id_ext     = {{AW{1'b0}}, i_req.handle_id};
        id_addr    = id_ext[AW-1:0];
        in_range   = 32'(i_req.handle_id) < 32'(MAX_HANDLES);
        gen_match  = 32'(i_row_gen) == i_req.handle_gen;
        id_p1      = CW'(i_req.handle_id) + CW'(1);
        gen_masked = i_req.handle_gen[GEN_BITS-1:0];
        nid        = (i_count != '0) ? i_top_id : i_next_id[AW-1:0];
        nid_ext    = {{ID_W{1'b0}}, nid};

        o_upd       = '0;
        o_row_addr  = id_addr;
        o_row_gen   = i_row_gen;
        o_next_id   = i_next_id;
        o_rsp.out_id  = i_req.handle_id;
        o_rsp.out_gen = i_req.handle_gen;
        o_rsp.ok      = 1'b0;

        case (i_req.op)
            OP_CREATE: begin
                if (i_count != '0 || i_next_id < CW'(MAX_HANDLES)) begin
                    o_upd.row_we   = 1'b1;
                    o_upd.row_live = 1'b1;
                    o_row_addr     = nid;
                    if (i_count != '0) begin
                        o_upd.pop = 1'b1;
                    end else begin
                        // counter ids have never been written since the last sweep
                        o_row_gen = '0;
                        o_next_id = i_next_id + CW'(1);
                    end
                    o_rsp.out_id  = nid_ext[ID_W-1:0];
                    o_rsp.out_gen = 32'(o_row_gen);
                    o_rsp.ok      = 1'b1;
                end else begin
                    // exhausted
                    o_rsp = '0;
                end
            end
            OP_CREATE_AT: begin
                if (in_range) begin
                    o_upd.row_we   = 1'b1;
                    o_upd.row_live = 1'b1;
                    o_row_gen      = gen_masked;
                    if (id_p1 > i_next_id) begin
                        o_next_id = id_p1;
                    end
                    o_rsp.out_gen = 32'(gen_masked);
                    o_rsp.ok      = 1'b1;
                end
            end
            OP_DESTROY: begin
                if (in_range && i_row_live && gen_match && i_count != CW'(MAX_HANDLES)) begin
                    o_upd.row_we = 1'b1;
                    o_upd.push   = 1'b1;
                    o_row_gen    = i_row_gen + GEN_BITS'(1);
                    o_rsp.ok     = 1'b1;
                end
            end
            OP_CHECK: begin
                o_rsp.ok = in_range && i_row_live && gen_match;
            end
            OP_CLEAR: begin
                o_upd.clear = 1'b1;
                o_next_id   = CW'(1);
                o_rsp.ok    = 1'b1;
            end
            default: begin
                o_rsp.ok = 1'b0;
            end
        endcase

        if (!i_valid) begin
            o_upd     = '0;
            o_next_id = i_next_id;
        end
    end

endmodule : gha_exec
`default_nettype wire

// ===== design/generational_handle_allocator_top.sv =====
`default_nettype none
// ============================================================================
// generational_handle_allocator_top
// Id/generation handle allocator with LIFO id reuse and per-id live bits.
// ============================================================================
// Each request beat carries create, create-at-id, destroy, check or clear and
// yields exactly one response beat. Requests flow through three registers:
// the request register (free stack top is read), the lookup register (the
// per-id row of live bit and generation is read), and the response register
// (result and all state writes). One request is taken per cycle, so
// throughput is one beat per cycle, with two exceptions: a create is held
// off while a destroy sits in the request register (the destroy's push is
// only known once its row has been read), and a clear blocks new requests
// until it has left the pipeline and the per-id table has been swept, one
// row per cycle. The same sweep runs right after reset, so the block takes
// no request until that sweep is done. A stalled response beat freezes the
// whole pipeline.
module generational_handle_allocator_top
    import gha_pkg::*;
#(
    parameter int MAX_HANDLES = MAX_HANDLES_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    localparam int AW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(MAX_HANDLES + 1);
    localparam int RW = GEN_BITS + 1;   // {live, generation}

    // pipeline registers
    logic          r_s1_valid;
    t_req          r_s1_req;
    logic          r_s1_fwd_stk;
    logic [AW-1:0] r_s1_fwd_id;
    logic          r_s2_valid;
    t_req          r_s2_req;
    logic [AW-1:0] r_s2_top;
    logic          r_s2_fwd_row;
    logic [RW-1:0] r_s2_fwd_data;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    // allocator state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_next_id;
    logic          r_sweep;
    logic [AW-1:0] r_sweep_addr;

    logic          adv;
    logic          blocked;
    logic          acc;
    logic          commit;

    logic [AW-1:0] stk_raddr;
    logic [AW-1:0] stk_rdata;
    logic          stk_we;
    logic          stk_fwd;
    logic [CW-1:0] cnt_s2;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] cnt_m1;

    logic [AW+ID_W-1:0] s1_id_ext;
    logic [AW-1:0] s1_top;
    logic [AW-1:0] row_raddr;
    logic [RW-1:0] row_rdata;
    logic [RW-1:0] row_cur;
    logic          row_we;
    logic [AW-1:0] row_waddr;
    logic [RW-1:0] row_wdata;
    logic          row_fwd;

    t_upd          upd;
    logic [AW-1:0] ex_row_addr;
    logic [GEN_BITS-1:0] ex_row_gen;
    logic [CW-1:0] ex_next_id;
    t_rsp          ex_rsp;

    // ---------------------------------------------------------------- control
    assign adv     = !r_rsp_valid || i_rsp_ready;
    assign commit  = adv && r_s2_valid;
    assign blocked = r_sweep
                  || (r_s1_valid && r_s1_req.op == OP_CLEAR)
                  || (r_s2_valid && r_s2_req.op == OP_CLEAR)
                  || (i_req.op == OP_CREATE && r_s1_valid && r_s1_req.op == OP_DESTROY);
    assign o_req_ready = adv && !blocked;
    assign acc         = i_req_valid && o_req_ready;

    // ------------------------------------------------------- execute stage
    assign row_cur = r_s2_fwd_row ? r_s2_fwd_data : row_rdata;

    gha_exec #(
        .MAX_HANDLES (MAX_HANDLES),
        .GEN_BITS    (GEN_BITS)
    ) u_exec (
        .i_valid    (r_s2_valid),
        .i_req      (r_s2_req),
        .i_row_live (row_cur[RW-1]),
        .i_row_gen  (row_cur[GEN_BITS-1:0]),
        .i_top_id   (r_s2_top),
        .i_count    (r_count),
        .i_next_id  (r_next_id),
        .o_upd      (upd),
        .o_row_addr (ex_row_addr),
        .o_row_gen  (ex_row_gen),
        .o_next_id  (ex_next_id),
        .o_rsp      (ex_rsp)
    );

    // free count after the execute stage, then after the request register;
    // the new beat reads the stack top at that count
    always_comb begin
        cnt_s2 = r_count;
        if (upd.clear) begin
            cnt_s2 = '0;
        end else if (upd.push) begin
            cnt_s2 = r_count + CW'(1);
        end else if (upd.pop) begin
            cnt_s2 = r_count - CW'(1);
        end

        cnt_eff = cnt_s2;
        if (r_s1_valid && r_s1_req.op == OP_CREATE && cnt_s2 != '0) begin
            cnt_eff = cnt_s2 - CW'(1);
        end
        cnt_m1    = cnt_eff - CW'(1);
        stk_raddr = cnt_m1[AW-1:0];
    end

    // ----------------------------------------------------------- free stack
    assign stk_we  = commit && upd.push;
    assign stk_fwd = stk_we && (r_count[AW-1:0] == stk_raddr);

    gha_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_HANDLES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ex_row_addr),
        .i_re    (adv),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // ------------------------------------------------------ live/gen table
    assign s1_id_ext = {{AW{1'b0}}, r_s1_req.handle_id};
    assign s1_top    = r_s1_fwd_stk ? r_s1_fwd_id : stk_rdata;
    assign row_raddr = (r_s1_req.op == OP_CREATE) ? s1_top : s1_id_ext[AW-1:0];

    always_comb begin
        if (r_sweep) begin
            row_we    = 1'b1;
            row_waddr = r_sweep_addr;
            row_wdata = '0;
        end else begin
            row_we    = commit && upd.row_we;
            row_waddr = ex_row_addr;
            row_wdata = {upd.row_live, ex_row_gen};
        end
    end

    // an older beat writing the row being read this cycle
    assign row_fwd = commit && upd.row_we && (ex_row_addr == row_raddr);

    gha_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_HANDLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (adv),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_rsp_valid  <= 1'b0;
            r_count      <= '0;
            r_next_id    <= CW'(1);
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            if (adv) begin
                r_s1_valid  <= acc;
                r_s2_valid  <= r_s1_valid;
                r_rsp_valid <= r_s2_valid;
                r_count     <= cnt_s2;
                r_next_id   <= ex_next_id;
            end
            if (commit && upd.clear) begin
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == AW'(MAX_HANDLES - 1)) begin
                    r_sweep <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_req      <= i_req;
            r_s1_fwd_stk  <= stk_fwd;
            r_s1_fwd_id   <= ex_row_addr;
            r_s2_req      <= r_s1_req;
            r_s2_top      <= s1_top;
            r_s2_fwd_row  <= row_fwd;
            r_s2_fwd_data <= {upd.row_live, ex_row_gen};
            r_rsp         <= ex_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule : generational_handle_allocator_top
`default_nettype wire

// ===== tb/gha_checker.sv =====
// ============================================================================
// gha_checker
// Watches both channels of the handle allocator and predicts every response.
// It keeps its own copy of the id stack and the per-id tables. Each response
// beat is compared field by field with the oldest prediction.
// ============================================================================
module gha_checker
    import gha_pkg::*;
#(
    parameter int MAX_HANDLES = MAX_HANDLES_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [GEN_W-1:0] GEN_MASK = GEN_W'((64'd1 << GEN_BITS) - 64'd1);

    // shadow allocator state
    logic [ID_W-1:0]  free_ids [MAX_HANDLES];
    int               free_top;
    int               next_new_id;
    logic [GEN_W-1:0] gen_of [MAX_HANDLES];
    bit               gen_seen [MAX_HANDLES];
    bit               is_live [MAX_HANDLES];

    t_rsp pending_rsp[$];
    t_rsp want;
    int   fail_count = 0;

    assign o_fail_count = fail_count;

    // ids never touched read as generation zero
    function automatic logic [GEN_W-1:0] stored_gen(int id);
        return gen_seen[id] ? gen_of[id] : '0;
    endfunction

    function automatic void forget_all();
        for (int i = 0; i < MAX_HANDLES; i++) begin
            gen_seen[i] = 1'b0;
            is_live[i]  = 1'b0;
        end
        free_top    = 0;
        next_new_id = 1;
    endfunction

    // applies one request to the shadow state, returns its response
    function automatic t_rsp apply_handle_op(t_req r);
        t_rsp             res;
        int               id;
        int               nid;
        bit               in_range;
        logic [GEN_W-1:0] g;
        id       = int'(r.handle_id);
        in_range = id < MAX_HANDLES;
        res      = '{out_id: r.handle_id, out_gen: r.handle_gen, ok: 1'b0};
        case (r.op)
            OP_CREATE: begin
                nid = -1;
                if (free_top > 0) begin
                    free_top--;
                    nid = int'(free_ids[free_top]);
                end else if (next_new_id < MAX_HANDLES) begin
                    nid = next_new_id;
                    next_new_id++;
                end
                if (nid < 0) begin
                    res = '0;  // exhausted
                end else begin
                    g              = stored_gen(nid);
                    gen_of[nid]    = g;
                    gen_seen[nid]  = 1'b1;
                    is_live[nid]   = 1'b1;
                    res            = '{out_id: ID_W'(nid), out_gen: g, ok: 1'b1};
                end
            end
            OP_CREATE_AT: begin
                if (in_range) begin
                    g            = r.handle_gen & GEN_MASK;
                    gen_of[id]   = g;
                    gen_seen[id] = 1'b1;
                    is_live[id]  = 1'b1;
                    if (id + 1 > next_new_id) next_new_id = id + 1;
                    res.out_gen = g;
                    res.ok      = 1'b1;
                end
            end
            OP_DESTROY: begin
                if (in_range && is_live[id] && stored_gen(id) == r.handle_gen &&
                    free_top < MAX_HANDLES) begin
                    gen_of[id]         = (gen_of[id] + 1'b1) & GEN_MASK;
                    gen_seen[id]       = 1'b1;
                    free_ids[free_top] = r.handle_id;
                    free_top++;
                    is_live[id] = 1'b0;
                    res.ok      = 1'b1;
                end
            end
            OP_CHECK: begin
                res.ok = in_range && is_live[id] && stored_gen(id) == r.handle_gen;
            end
            OP_CLEAR: begin
                forget_all();
                res.ok = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            forget_all();
            pending_rsp.delete();
        end else begin
            // compare first: a beat is never matched against a request of the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    $error("unexpected response beat: out_id %0d out_gen %0h ok %0b",
                           i_rsp.out_id, i_rsp.out_gen, i_rsp.ok);
                    fail_count++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (i_rsp.out_id !== want.out_id) begin
                        $error("out_id: expected %0d, actual %0d", want.out_id, i_rsp.out_id);
                        fail_count++;
                    end
                    if (i_rsp.out_gen !== want.out_gen) begin
                        $error("out_gen: expected %0h, actual %0h",
                               want.out_gen, i_rsp.out_gen);
                        fail_count++;
                    end
                    if (i_rsp.ok !== want.ok) begin
                        $error("ok: expected %0b, actual %0b", want.ok, i_rsp.ok);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                pending_rsp.insert(pending_rsp.size(), apply_handle_op(i_req));
        end
        o_pending = pending_rsp.size();
    end

endmodule : gha_checker

// ===== tb/tb_generational_handle_allocator_top.sv =====
// ============================================================================
// tb_generational_handle_allocator_top
// Stimulus and verdict for the generational handle allocator.
// A directed opener walks through create, reuse, exhaustion, generation wrap,
// re-creating a freed id, unknown ops and clear. A run of freed ids pushed
// onto the stack and popped back, and random traffic built around handles
// the block actually handed out follow, under three idle profiles.
// Checking lives in gha_checker.
// ============================================================================
module tb_generational_handle_allocator_top;
    import gha_pkg::*;

    localparam int MAX_HANDLES      = MAX_HANDLES_DEF;
    localparam int RANDOM_PER_PHASE = 370;
    localparam int STACK_RUN        = 40;
    // the clear sweep moves no beat while it runs; the limit leaves room for it
    localparam int WATCHDOG_LIMIT   = 4 * MAX_HANDLES;
    localparam int POOL_DEPTH       = 48;
    localparam int SMALL_ID_MAX     = 47;
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_CLEAR) + 1'b1;

    // a handle seen in a successful create response
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [GEN_W-1:0] gen;
    } t_handle;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    int chk_fail_count;
    int chk_pending;

    // idle rates in percent, changed per phase
    int tx_idle_pct = 11;
    int rx_idle_pct = 77;

    int               idle_cycles = 0;
    logic [OP_W-1:0]  sent_ops[$];     // ops in flight, used to learn handles
    logic [OP_W-1:0]  done_op;
    t_handle          live_handles[$]; // handles believed live, for destroy/check
    logic [ID_W-1:0]  fill_id;
    logic [GEN_W-1:0] fill_gen;

    generational_handle_allocator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    gha_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver backpressure
    always @(posedge clk) begin
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog: cycles in which neither channel moves a beat
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Learn handles from the responses so that destroy and check mostly hit
    // live ids with their current generation. Only shapes stimulus.
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready && sent_ops.size() != 0) begin
                done_op = sent_ops.pop_front();
                if (rsp.ok) begin
                    case (done_op)
                        OP_CREATE, OP_CREATE_AT: begin
                            if (live_handles.size() >= POOL_DEPTH)
                                live_handles[$urandom_range(0, POOL_DEPTH - 1)] =
                                    '{id: rsp.out_id, gen: rsp.out_gen};
                            else
                                live_handles.insert(live_handles.size(),
                                    t_handle'{id: rsp.out_id, gen: rsp.out_gen});
                        end
                        OP_DESTROY: begin
                            for (int k = live_handles.size() - 1; k >= 0; k--)
                                if (live_handles[k].id == rsp.out_id) live_handles.delete(k);
                        end
                        OP_CLEAR: live_handles.delete();
                        default: ;
                    endcase
                end
            end
            if (req_valid && req_ready) sent_ops.insert(sent_ops.size(), req.op);
        end
    end

    // One request beat. Valid stays up between back-to-back beats; it only
    // drops when an idle gap is drawn, so it gets one update per edge.
    task automatic send_req(input t_req r);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int id,
                           input logic [GEN_W-1:0] gen);
        t_req r;
        r.op         = op;
        r.handle_id  = ID_W'(id);
        r.handle_gen = gen;
        send_req(r);
    endtask

    // Sender holds off until every predicted response has come back. It lets
    // the clock advance first so the last accepted beat is surely counted as pending.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
    endtask

    // mostly a known handle, sometimes with a flipped generation bit or a random id
    function automatic t_handle pick_handle();
        t_handle h;
        if (live_handles.size() == 0) begin
            h.id  = ID_W'($urandom_range(0, SMALL_ID_MAX));
            h.gen = '0;
        end else begin
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        end
        if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 1)) h.gen ^= GEN_W'(1) << $urandom_range(0, GEN_W - 1);
            else h.id = ID_W'($urandom);
        end
        return h;
    endfunction

    function automatic t_req random_request();
        t_req    r;
        t_handle h;
        int      roll;
        r.op         = OP_CREATE;
        r.handle_id  = ID_W'($urandom);
        r.handle_gen = $urandom;
        roll         = $urandom_range(0, 99);
        if (roll < 28) begin
            r.op = OP_CREATE;
        end else if (roll < 40) begin
            r.op = OP_CREATE_AT;
            // small ids keep the stack busy, large ones push toward exhaustion
            if ($urandom_range(0, 99) < 75) r.handle_id = ID_W'($urandom_range(0, SMALL_ID_MAX));
            case ($urandom_range(0, 4))
                0, 1, 2: r.handle_gen = GEN_W'($urandom_range(0, 7));
                3:       r.handle_gen = '1 - GEN_W'($urandom_range(0, 2));  // near wrap
                default: ;
            endcase
        end else if (roll < 95) begin
            h            = pick_handle();
            r.op         = (roll < 66) ? OP_DESTROY : OP_CHECK;
            r.handle_id  = h.id;
            r.handle_gen = h.gen;
        end else if (roll == 95) begin
            r.op = OP_CLEAR;
        end else if (roll == 96) begin
            r.op = OP_W'($urandom_range(int'(OP_FIRST_UNUSED), (1 << OP_W) - 1));
        end else begin
            r.op = OP_CHECK;  // random id and generation, mostly a miss
        end
        return r;
    endfunction

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed opener (sender 11%, receiver 77% idle) ----
        send_op(OP_CHECK, 0, '0);                    // never seen: invalid
        send_op(OP_CREATE, 0, '0);                   // counter starts at 1
        send_op(OP_CHECK, 1, '0);
        send_op(OP_DESTROY, 1, 32'd5);               // generation mismatch
        send_op(OP_DESTROY, 1, '0);                  // frees id 1, gen -> 1
        send_op(OP_DESTROY, 1, '0);                  // no longer live
        send_op(OP_CREATE, 0, '0);                   // reuses id 1 at gen 1
        send_op(OP_CREATE_AT, MAX_HANDLES - 1, '1);  // counter jumps to the end
        send_op(OP_CREATE, 0, '0);                   // exhausted
        send_op(OP_DESTROY, MAX_HANDLES - 1, '1);    // generation wraps to zero
        send_op(OP_CHECK, MAX_HANDLES - 1, '1);
        send_op(OP_CREATE, 0, '0);                   // pops top id at gen 0
        send_op(OP_CHECK, MAX_HANDLES - 1, '0);
        send_op(OP_CREATE_AT, MAX_HANDLES - 1, 32'h55);  // create-at on a live id
        send_op(OP_DESTROY, MAX_HANDLES - 1, 32'h55);
        // re-create while still on the free stack, then a create hands it out again
        send_op(OP_CREATE_AT, MAX_HANDLES - 1, 32'hAAAA_AAAA);
        send_op(OP_CREATE, 0, '0);
        send_op(OP_CREATE_AT, 0, '0);                // id zero only via create-at
        send_op(OP_CHECK, 0, '0);
        for (int k = int'(OP_FIRST_UNUSED); k < (1 << OP_W); k++)
            send_op(OP_W'(k), $urandom, $urandom);   // unknown ops echo and fail
        send_op(OP_CLEAR, 10'h155, 32'h1234_5678);
        send_op(OP_CHECK, 1, 32'd1);                 // gone after clear
        send_op(OP_CREATE, 10'h2AA, 32'h5A5A_A5A5);  // counter restarts at 1

        repeat (RANDOM_PER_PHASE) send_req(random_request());
        wait_for_results();

        // ---- sender 77%, receiver 11% idle ----
        tx_idle_pct = 77;
        rx_idle_pct = 11;

        // Stack a run of freed ids: create-at then destroy of the same handle
        // pushes one entry each time, duplicates included. Creates pop them back.
        send_op(OP_CLEAR, 0, '0);
        for (int k = 0; k < STACK_RUN; k++) begin
            fill_id  = ID_W'($urandom);
            fill_gen = $urandom;
            send_op(OP_CREATE_AT, int'(fill_id), fill_gen);
            send_op(OP_DESTROY, int'(fill_id), fill_gen);
        end
        repeat (STACK_RUN) send_op(OP_CREATE, $urandom, $urandom);

        repeat (RANDOM_PER_PHASE) send_req(random_request());
        wait_for_results();

        // ---- no idling on either side ----
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_req(random_request());
        wait_for_results();

        // pipeline is three deep; a few spare cycles catch stray beats
        repeat (8) @(posedge clk);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb_generational_handle_allocator_top
